>>> src/assert_macros.svh
// Assertion macros used by the RTL of the pixel dimming table.
// Every macro expects a clock named clk; LPDT_ASSERT also expects an active-low reset named rst_n.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every clock edge outside reset.
`define LPDT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Checked on every clock edge, reset included.
`define LPDT_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

>>> src/lpdt_pkg.sv
// Package of the LED pixel dimming table: sizes, action codes, label and default ROMs
// and the status struct of the scaling unit. Depends on nothing.
package lpdt_pkg;

  localparam int PIXEL_COUNT = 96;
  localparam int IDX_W       = $clog2(PIXEL_COUNT + 1);
  localparam int WIDTH_W     = 10;
  localparam int PCT_W       = 7;

  typedef logic [IDX_W-1:0]   pix_idx_t;
  typedef logic [WIDTH_W-1:0] width_t;
  typedef logic [PCT_W-1:0]   pct_t;
  typedef logic [2:0]         action_t;
  typedef logic [4:0]         row_t;

  localparam width_t WIDTH_LIMIT = 10'd1023;
  localparam pct_t   PCT_LIMIT   = 7'd100;

  localparam action_t ACT_LOAD   = 3'd0;
  localparam action_t ACT_CLAMP  = 3'd1;
  localparam action_t ACT_SET    = 3'd2;
  localparam action_t ACT_LABEL  = 3'd3;
  localparam action_t ACT_MASK   = 3'd4;
  localparam action_t ACT_WINDOW = 3'd5;
  localparam action_t ACT_READ   = 3'd6;

  // LED string of each pixel: A=0, B=1, C=2, D=3.
  localparam logic [1:0] LABEL_STRING [PIXEL_COUNT] = '{
    2,3,2,3,2,3,2,3,2,3,2,3,2,3,2,3,
    0,1,2,3,0,1,2,3,0,1,2,0,1,2,0,1,
    0,1,0,1,0,1,0,1,0,1,0,1,0,1,0,1,
    0,1,0,1,0,1,0,1,0,1,0,1,0,1,0,1,
    0,1,0,1,2,0,1,2,0,1,2,3,0,1,2,3,
    2,3,2,3,2,3,2,3,2,3,2,3,2,3,2,3
  };

  // LED row of each pixel, 1 to 26.
  localparam row_t LABEL_ROW [PIXEL_COUNT] = '{
    14,14,15,15,16,16,17,17,18,18,19,19,20,20,21,21,
    22,22,22,22,23,23,23,23,24,24,24,25,25,25,26,26,
    14,14,15,15,16,16,17,17,18,18,19,19,20,20,21,21,
     6, 6, 7, 7, 8, 8, 9, 9,10,10,11,11,12,12,13,13,
     1, 1, 2, 2, 2, 3, 3, 3, 4, 4, 4, 4, 5, 5, 5, 5,
     6, 6, 7, 7, 8, 8, 9, 9,10,10,11,11,12,12,13,13
  };

  localparam width_t DEFAULT_WIDTH [PIXEL_COUNT] = '{
    379, 123, 512, 205, 573, 205, 614, 164, 368, 164, 256,  82, 184,  82, 205,  82,
    276, 276, 153,  82, 256, 256, 153,  82, 246, 246, 174, 286, 297, 143, 307, 307,
    675, 675, 900, 900,1023,1023, 900, 900, 655, 655, 450, 450, 338, 338, 276, 276,
    266, 266, 286, 286, 297, 297, 297, 307, 317, 317, 338, 338, 368, 368, 409, 471,
    225, 225, 225, 235, 123, 235, 235, 123, 256, 256, 143,  41, 256, 256, 143,  41,
    153,  41, 164,  61, 164,  61, 164,  61, 174,  61, 184,  72, 205,  82, 266, 123
  };

  typedef struct packed {
    logic     busy;
    logic     vld;
    pix_idx_t idx;
    width_t   value;
  } lpdt_scale_out_t;

endpackage

>>> src/lpdt_in_if.sv
// Command channel of the pixel dimming table: valid, ready and one action item.
// Depends on lpdt_pkg.
interface lpdt_in_if;
  import lpdt_pkg::*;

  logic        valid;
  logic        ready;
  action_t     action;
  logic [7:0]  pixel_index;
  logic [7:0]  string_id;
  logic [7:0]  led_row;
  logic [15:0] new_width;
  logic [7:0]  scale_percent;
  logic [15:0] max_width;
  logic [3:0]  keep_mask;
  logic [7:0]  row_first;
  logic [7:0]  row_last;

  modport source (
    output valid, action, pixel_index, string_id, led_row, new_width,
           scale_percent, max_width, keep_mask, row_first, row_last,
    input  ready
  );
  modport sink (
    input  valid, action, pixel_index, string_id, led_row, new_width,
           scale_percent, max_width, keep_mask, row_first, row_last,
    output ready
  );
endinterface

>>> src/lpdt_out_if.sv
// Result channel of the pixel dimming table: valid, ready and one result item.
// Depends on lpdt_pkg.
interface lpdt_out_if;
  import lpdt_pkg::*;

  logic   valid;
  logic   ready;
  logic   found;
  width_t read_width;
  logic   done_res;

  modport source (output valid, found, read_width, done_res, input ready);
  modport sink   (input valid, found, read_width, done_res, output ready);
endinterface

>>> src/led_pixel_dimming_table.sv
// LED pixel dimming table: 96 ten-bit dimming widths for a matrix headlamp.
//
// Commands arrive as items on in_ch (valid/ready); each gives exactly one result item
// on out_ch (found, read_width, done_res = 1). An item is taken only while the block
// is idle, so commands are processed one at a time.
// Path from acceptance to the result being presented:
//   set pixel, read, unused code : the ST_SINGLE step, then ST_FINISH
//   string mask, dark window     : a sweep of all entries (one store entry per cycle)
//   set by label                 : a sweep that stops early when the label matches
//   clamp                        : a sweep that reads, compares, writes back, pipelined
//   load scaled                  : a sweep through a two-stage multiply by a reciprocal
// The single write port of the width store, one entry a cycle, paces every sweep.
// The next item is taken at the earliest in the cycle after the result is loaded.
// The result sits in an output register; if the receiver stalls, it is held there and
// the next command may be accepted, but that command's result waits until the register
// is free. After reset all 96 store entries are swept to zero, during which in_ch
// ready stays low; results are never lost.
// Depends on lpdt_pkg, lpdt_in_if, lpdt_out_if, lpdt_scale and assert_macros.svh.
module led_pixel_dimming_table (
  input logic       clk,
  input logic       rst_n,
  lpdt_in_if.sink   in_ch,
  lpdt_out_if.source out_ch
);
  import lpdt_pkg::*;

  localparam logic [2:0] ST_CLEAR  = 3'd0;
  localparam logic [2:0] ST_IDLE   = 3'd1;
  localparam logic [2:0] ST_SWEEP  = 3'd2;
  localparam logic [2:0] ST_SINGLE = 3'd3;
  localparam logic [2:0] ST_FINISH = 3'd4;

  localparam pix_idx_t LAST_IDX = IDX_W'(PIXEL_COUNT - 1);
  localparam pix_idx_t END_IDX  = IDX_W'(PIXEL_COUNT);

  logic [2:0] state_r, state_nxt;
  pix_idx_t   idx_r;
  logic       found_r;

  action_t    action_r;
  logic [7:0] pix_r;
  logic [7:0] str_r;
  logic [7:0] row_r;
  width_t     wnew_r;
  pct_t       pct_r;
  width_t     wmax_r;
  logic [3:0] keep_r;
  logic [7:0] first_r;
  logic [7:0] last_r;

  logic       s1_vld_r;
  pix_idx_t   s1_idx_r;
  width_t     rd_q_r;

  logic       out_vld_r;
  logic       out_found_r;
  width_t     out_rd_r;

  width_t     store_mem [PIXEL_COUNT];

  logic       accept;
  logic       issue;
  logic       pix_ok;
  logic       label_hit;
  logic       mask_hit;
  logic       window_hit;
  logic       sweep_done;
  logic       clamp_wr;
  logic       out_load;
  logic       we;
  pix_idx_t   wa;
  width_t     wd;
  logic       ren;
  pix_idx_t   ra;
  lpdt_scale_out_t sc_status;

  assign accept  = in_ch.valid && in_ch.ready;
  assign in_ch.ready = (state_r == ST_IDLE);

  assign issue  = (state_r == ST_SWEEP) && (idx_r < END_IDX);
  assign pix_ok = pix_r < 8'(PIXEL_COUNT);

  // Label, mask and window decisions come from the label ROMs and the command, so they need no store read.
  assign label_hit  = issue && (action_r == ACT_LABEL)
                      && (str_r == {6'd0, LABEL_STRING[idx_r]})
                      && (row_r == {3'd0, LABEL_ROW[idx_r]});
  assign mask_hit   = issue && (action_r == ACT_MASK) && !keep_r[LABEL_STRING[idx_r]];
  assign window_hit = issue && (action_r == ACT_WINDOW) && (first_r <= last_r)
                      && ({3'd0, LABEL_ROW[idx_r]} >= first_r)
                      && ({3'd0, LABEL_ROW[idx_r]} <= last_r);
  assign clamp_wr   = s1_vld_r && (rd_q_r > wmax_r);

  assign sweep_done = (idx_r == END_IDX) && !s1_vld_r && !sc_status.busy;
  assign out_load   = (state_r == ST_FINISH) && (!out_vld_r || out_ch.ready);

  lpdt_scale u_scale (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_vld (issue && (action_r == ACT_LOAD)),
    .in_idx (idx_r),
    .pct    (pct_r),
    .status (sc_status)
  );

  // One write port: only one source can be active for a given action.
  always_comb begin
    we = 1'b0;
    wa = idx_r;
    wd = '0;
    case (state_r)
      ST_CLEAR: begin
        we = 1'b1;
      end
      ST_SWEEP: begin
        if (label_hit) begin
          we = 1'b1;
          wd = wnew_r;
        end else if (mask_hit || window_hit) begin
          we = 1'b1;
        end else if (clamp_wr) begin
          we = 1'b1;
          wa = s1_idx_r;
          wd = wmax_r;
        end else if (sc_status.vld) begin
          we = 1'b1;
          wa = sc_status.idx;
          wd = sc_status.value;
        end
      end
      ST_SINGLE: begin
        if ((action_r == ACT_SET) && pix_ok) begin
          we = 1'b1;
          wa = pix_r[IDX_W-1:0];
          wd = wnew_r;
        end
      end
      default: begin
        we = 1'b0;
      end
    endcase
  end

  always_comb begin
    ren = 1'b0;
    ra  = idx_r;
    if (issue && (action_r == ACT_CLAMP)) begin
      ren = 1'b1;
    end else if ((state_r == ST_SINGLE) && (action_r == ACT_READ) && pix_ok) begin
      ren = 1'b1;
      ra  = pix_r[IDX_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      store_mem[wa] <= wd;
    end
    if (ren) begin
      rd_q_r <= store_mem[ra];
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_CLEAR: begin
        if (idx_r == LAST_IDX) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          if (in_ch.action inside {ACT_LOAD, ACT_CLAMP, ACT_LABEL, ACT_MASK, ACT_WINDOW}) begin
            state_nxt = ST_SWEEP;
          end else begin
            state_nxt = ST_SINGLE;
          end
        end
      end
      ST_SWEEP: begin
        if (sweep_done) begin
          state_nxt = ST_FINISH;
        end
      end
      ST_SINGLE: begin
        state_nxt = ST_FINISH;
      end
      ST_FINISH: begin
        if (out_load) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_CLEAR;
      idx_r     <= '0;
      found_r   <= 1'b0;
      s1_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      s1_vld_r <= issue && (action_r == ACT_CLAMP);
      if (state_r == ST_CLEAR) begin
        idx_r <= idx_r + 1'b1;
      end else if (accept) begin
        idx_r   <= '0;
        found_r <= 1'b0;
      end else if (label_hit) begin
        idx_r   <= END_IDX;
        found_r <= 1'b1;
      end else if (issue) begin
        idx_r <= idx_r + 1'b1;
      end
      if (out_load) begin
        out_vld_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    s1_idx_r <= idx_r;
    if (accept) begin
      action_r <= in_ch.action;
      pix_r    <= in_ch.pixel_index;
      str_r    <= in_ch.string_id;
      row_r    <= in_ch.led_row;
      wnew_r   <= (in_ch.new_width > {6'd0, WIDTH_LIMIT}) ? WIDTH_LIMIT
                                                         : in_ch.new_width[WIDTH_W-1:0];
      pct_r    <= (in_ch.scale_percent > {1'b0, PCT_LIMIT}) ? PCT_LIMIT
                                                            : in_ch.scale_percent[PCT_W-1:0];
      wmax_r   <= (in_ch.max_width > {6'd0, WIDTH_LIMIT}) ? WIDTH_LIMIT
                                                         : in_ch.max_width[WIDTH_W-1:0];
      keep_r   <= in_ch.keep_mask;
      first_r  <= in_ch.row_first;
      last_r   <= in_ch.row_last;
    end
    if (out_load) begin
      out_found_r <= found_r;
      out_rd_r    <= ((action_r == ACT_READ) && pix_ok) ? rd_q_r : '0;
    end
  end

  assign out_ch.valid      = out_vld_r;
  assign out_ch.found      = out_found_r;
  assign out_ch.read_width = out_rd_r;
  assign out_ch.done_res   = 1'b1;

  `include "assert_macros.svh"

  `LPDT_ASSERT(a_wr_in_range, we |-> (wa < END_IDX), "store write beyond last pixel")
  `LPDT_ASSERT(a_one_writer, !(clamp_wr && sc_status.vld), "two writers on the store port")
  `LPDT_ASSERT(a_found_label, ((state_r == ST_FINISH) && found_r) |-> (action_r == ACT_LABEL),
               "found flag raised outside a set by label")
  `LPDT_ASSERT(a_sweep_drained,
               ((state_r == ST_SWEEP) && (state_nxt == ST_FINISH)) |->
               (!s1_vld_r && !sc_status.busy), "sweep left with writes in flight")
  `LPDT_ASSERT(a_no_drop, (out_vld_r && !out_ch.ready) |=> (out_vld_r && $stable(out_rd_r)),
               "stalled result changed")

endmodule

>>> src/lpdt_scale.sv
// Two-stage scaling pipe: default width of a pixel times a percent, divided by 100.
// Depends on lpdt_pkg.
module lpdt_scale (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_vld,
  input  lpdt_pkg::pix_idx_t        in_idx,
  input  lpdt_pkg::pct_t            pct,
  output lpdt_pkg::lpdt_scale_out_t status
);
  import lpdt_pkg::*;

  // x / 100 equals (x * 41944) >> 22 for every product of a default width and a
  // percent of at most 100; the rounding error only bites for products that never occur.
  localparam logic [15:0] RECIP       = 16'd41944;
  localparam int          RECIP_SHIFT = 22;
  localparam int          PROD_W      = WIDTH_W + PCT_W;
  localparam int          FULL_W      = PROD_W + 16;

  logic              s1_vld_r;
  pix_idx_t          s1_idx_r;
  logic [PROD_W-1:0] prod_r;
  logic              s2_vld_r;
  pix_idx_t          s2_idx_r;
  width_t            value_r;
  logic [PROD_W-1:0] prod_nxt;
  logic [FULL_W-1:0] full_prod;

  assign prod_nxt  = {{PCT_W{1'b0}}, DEFAULT_WIDTH[in_idx]} * {{WIDTH_W{1'b0}}, pct};
  assign full_prod = {16'd0, prod_r} * {{PROD_W{1'b0}}, RECIP};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
      s2_vld_r <= 1'b0;
    end else begin
      s1_vld_r <= in_vld;
      s2_vld_r <= s1_vld_r;
    end
    prod_r   <= prod_nxt;
    s1_idx_r <= in_idx;
    s2_idx_r <= s1_idx_r;
    value_r  <= full_prod[RECIP_SHIFT +: WIDTH_W];
  end

  assign status.busy  = s1_vld_r | s2_vld_r;
  assign status.vld   = s2_vld_r;
  assign status.idx   = s2_idx_r;
  assign status.value = value_r;

endmodule
